// ===== design/eps_pkg.sv =====
// Package for the encoder position/speed estimator: widths, word types,
// register indexes and sequencer states. No dependencies.
`default_nettype none

package eps_pkg;

    // Core sizing
    localparam int COUNT_WIDTH = 32;   // position counter width, 16..48
    localparam int TIME_WIDTH  = 32;   // timestamp bits used, 16..32

    // Fixed field widths
    localparam int NUM_W   = 32;       // speed numerator / quotient width
    localparam int SCALE_W = 24;
    localparam int ALPHA_W = 16;
    localparam int SPEED_W = 32;
    localparam int POS_W   = 56;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    // Divider step counter
    localparam int DIV_CNT_W = $clog2(NUM_W);

    // Shared multiplier: signed A (count or speed) times signed B (weights, scale)
    localparam int MUL_A_W = (COUNT_WIDTH > SPEED_W) ? COUNT_WIDTH : SPEED_W;
    localparam int MUL_B_W = SCALE_W + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Filter accumulator: alpha*old + (1-alpha)*raw + half fits in 50 bits
    localparam int ACC_W = SPEED_W + ALPHA_W + 2;
    localparam int FILT_SHIFT = ALPHA_W;

    // Reset values of the configuration registers
    localparam logic [NUM_W-1:0]   SPEED_NUM_RESET = NUM_W'(2503475);
    localparam logic [SCALE_W-1:0] POS_SCALE_RESET = SCALE_W'(8724);
    localparam logic [ALPHA_W-1:0] ALPHA_RESET     = ALPHA_W'(59578);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_NUM = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_POS_SCALE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = CFG_IDX_W'(2);

    // Request codes
    localparam logic REQ_EDGE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic        level_a;
        logic        level_b;
        logic [31:0] time_us;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0]      position_count;
        logic signed [POS_W-1:0] position_scaled;
        logic signed [31:0]      speed_raw;
        logic signed [31:0]      speed_filtered;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SAT,
        ST_MUL_OLD,
        ST_MUL_RAW,
        ST_MUL_POS,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

// ===== design/eps_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on eps_pkg for widths.
`default_nettype none

module eps_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [eps_pkg::NUM_W-1:0]      i_num,
    input  wire logic [eps_pkg::TIME_WIDTH-1:0] i_den,
    output logic      [eps_pkg::NUM_W-1:0]      o_quo,
    output logic                                o_done
);

    logic [eps_pkg::NUM_W-1:0]      r_quo;
    logic [eps_pkg::TIME_WIDTH-1:0] r_rem;
    logic [eps_pkg::TIME_WIDTH-1:0] r_den;
    logic [eps_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic                           r_busy;
    logic                           r_done;

    logic [eps_pkg::TIME_WIDTH:0]   w_shift;
    logic [eps_pkg::TIME_WIDTH+1:0] w_diff;
    logic                           w_ge;

    // Shift in the next dividend bit and trial-subtract the divisor
    assign w_shift = {r_rem, r_quo[eps_pkg::NUM_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_den};
    assign w_ge    = ~w_diff[eps_pkg::TIME_WIDTH+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= eps_pkg::DIV_CNT_W'(eps_pkg::NUM_W - 1);
        end else if (r_busy) begin
            r_quo <= {r_quo[eps_pkg::NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[eps_pkg::TIME_WIDTH-1:0] : w_shift[eps_pkg::TIME_WIDTH-1:0];
            r_cnt <= r_cnt - eps_pkg::DIV_CNT_W'(1);
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== design/eps_mul.sv =====
// Shared signed multiplier with a registered product; holds while disabled.
// Depends on eps_pkg for operand widths.
`default_nettype none

module eps_mul (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire logic signed [eps_pkg::MUL_A_W-1:0]  i_a,
    input  wire logic signed [eps_pkg::MUL_B_W-1:0]  i_b,
    output logic signed      [eps_pkg::MUL_P_W-1:0]  o_prod
);

    logic signed [eps_pkg::MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= eps_pkg::MUL_P_W'(i_a) * eps_pkg::MUL_P_W'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== design/encoder_position_speed_estimator_core.sv =====
// Encoder channel: position counter and period speed estimator with low-pass filter.
// Edge word: taken without a stall, no result; ready again the next cycle.
// Tick word: from acceptance to the result register it runs through the 32-step serial
//   divider, one saturate, three shared multiplier passes and one load; input stalls
//   meanwhile, and also while a held result blocks the load.
// Reset (synchronous, active low): count, edge times, filter state cleared, forward, defaults.
`default_nettype none

module encoder_position_speed_estimator_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire eps_pkg::t_in_word               i_in_word,
    // result channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output eps_pkg::t_out_word                   o_out_word,
    // configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [eps_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [eps_pkg::CFG_W-1:0]       i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [eps_pkg::NUM_W-1:0]   r_speed_num;
    logic [eps_pkg::SCALE_W-1:0] r_pos_scale;
    logic [eps_pkg::ALPHA_W-1:0] r_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_num <= eps_pkg::SPEED_NUM_RESET;
            r_pos_scale <= eps_pkg::POS_SCALE_RESET;
            r_alpha     <= eps_pkg::ALPHA_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                eps_pkg::CFG_SPEED_NUM: r_speed_num <= i_cfg_data[eps_pkg::NUM_W-1:0];
                eps_pkg::CFG_POS_SCALE: r_pos_scale <= i_cfg_data[eps_pkg::SCALE_W-1:0];
                eps_pkg::CFG_ALPHA:     r_alpha     <= i_cfg_data[eps_pkg::ALPHA_W-1:0];
                default: ;  // unused index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Channel state
    // ------------------------------------------------------------------
    eps_pkg::t_state                     r_state, n_state;
    logic signed [eps_pkg::COUNT_WIDTH-1:0] r_count;
    logic                                r_dir_fwd;
    logic [eps_pkg::TIME_WIDTH-1:0]      r_time_last;
    logic [eps_pkg::TIME_WIDTH-1:0]      r_time_prior;
    logic signed [eps_pkg::SPEED_W-1:0] r_speed_state;

    // Tick working registers
    logic signed [eps_pkg::SPEED_W-1:0] r_raw;
    logic signed [eps_pkg::ACC_W-1:0]   r_acc;

    // Result register
    logic                r_out_valid;
    eps_pkg::t_out_word  r_out_word;

    logic                              w_in_acc;
    logic                              w_tick_acc;
    logic                              w_edge_acc;
    logic [eps_pkg::TIME_WIDTH-1:0]    w_gap;
    logic [eps_pkg::NUM_W-1:0]         w_quo;
    logic                              w_div_done;
    logic signed [eps_pkg::SPEED_W-1:0] w_raw_sat;
    logic signed [eps_pkg::SPEED_W-1:0] w_filt;

    // sequencer outputs
    logic                              w_mul_en;
    logic signed [eps_pkg::MUL_A_W-1:0] w_mul_a;
    logic signed [eps_pkg::MUL_B_W-1:0] w_mul_b;
    logic signed [eps_pkg::MUL_P_W-1:0] w_prod;
    logic                              w_out_load;

    assign o_in_stall = (r_state != eps_pkg::ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_tick_acc = w_in_acc && (i_in_word.req_type == eps_pkg::REQ_TICK);
    assign w_edge_acc = w_in_acc && (i_in_word.req_type == eps_pkg::REQ_EDGE);

    // Edge gap wraps modulo the timestamp width
    assign w_gap = r_time_last - r_time_prior;

    // ------------------------------------------------------------------
    // Shared units
    // ------------------------------------------------------------------
    eps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_tick_acc),
        .i_num   (r_speed_num),
        .i_den   (w_gap),
        .o_quo   (w_quo),
        .o_done  (w_div_done)
    );

    eps_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // Sign the quotient by direction and clamp to the 32-bit range.
    // A quotient with its top bit set is out of range either way.
    always_comb begin
        if (r_dir_fwd) begin
            w_raw_sat = w_quo[eps_pkg::NUM_W-1] ? 32'sh7FFF_FFFF : $signed(w_quo);
        end else begin
            w_raw_sat = w_quo[eps_pkg::NUM_W-1] ? 32'sh8000_0000 : -$signed(w_quo);
        end
    end

    // Floor of acc / 2^16 is an arithmetic shift; the result fits 32 bits
    assign w_filt = r_acc[eps_pkg::FILT_SHIFT +: eps_pkg::SPEED_W];

    // ------------------------------------------------------------------
    // Sequencer: next state and unit controls
    // ------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        w_mul_en   = 1'b0;
        w_mul_a    = eps_pkg::MUL_A_W'(r_speed_state);
        w_mul_b    = eps_pkg::MUL_B_W'({1'b0, r_alpha});
        w_out_load = 1'b0;
        unique case (r_state)
            eps_pkg::ST_IDLE: begin
                if (w_tick_acc) n_state = eps_pkg::ST_DIV;
            end
            eps_pkg::ST_DIV: begin
                if (w_div_done) n_state = eps_pkg::ST_SAT;
            end
            eps_pkg::ST_SAT: begin
                n_state = eps_pkg::ST_MUL_OLD;
            end
            eps_pkg::ST_MUL_OLD: begin
                // alpha * old speed
                w_mul_en = 1'b1;
                n_state  = eps_pkg::ST_MUL_RAW;
            end
            eps_pkg::ST_MUL_RAW: begin
                // (1 - alpha) * raw speed
                w_mul_en = 1'b1;
                w_mul_a  = eps_pkg::MUL_A_W'(r_raw);
                w_mul_b  = eps_pkg::MUL_B_W'(
                    {1'b0, (eps_pkg::ALPHA_W+1)'(1 << eps_pkg::ALPHA_W)} - {2'b00, r_alpha});
                n_state  = eps_pkg::ST_MUL_POS;
            end
            eps_pkg::ST_MUL_POS: begin
                // count * position scale
                w_mul_en = 1'b1;
                w_mul_a  = eps_pkg::MUL_A_W'(r_count);
                w_mul_b  = eps_pkg::MUL_B_W'({1'b0, r_pos_scale});
                n_state  = eps_pkg::ST_OUT;
            end
            eps_pkg::ST_OUT: begin
                // hold until the result register is free
                if (!r_out_valid || !i_out_stall) begin
                    w_out_load = 1'b1;
                    n_state    = eps_pkg::ST_IDLE;
                end
            end
            default: n_state = eps_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= eps_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Edge handling and filter state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_dir_fwd     <= 1'b1;
            r_time_last   <= '0;
            r_time_prior  <= '0;
            r_speed_state <= '0;
        end else begin
            if (w_edge_acc) begin
                // forward when A and B agree
                r_dir_fwd    <= (i_in_word.level_a == i_in_word.level_b);
                r_count      <= (i_in_word.level_a == i_in_word.level_b) ?
                                r_count + eps_pkg::COUNT_WIDTH'(1) :
                                r_count - eps_pkg::COUNT_WIDTH'(1);
                r_time_prior <= r_time_last;
                r_time_last  <= i_in_word.time_us[eps_pkg::TIME_WIDTH-1:0];
            end
            if (w_out_load) begin
                r_speed_state <= w_filt;
            end
        end
    end

    // Tick datapath: raw speed, then accumulate the two filter products
    always_ff @(posedge i_clk) begin
        if (r_state == eps_pkg::ST_SAT) begin
            r_raw <= (w_gap == '0) ? '0 : w_raw_sat;
        end
        if (r_state == eps_pkg::ST_MUL_RAW) begin
            r_acc <= eps_pkg::ACC_W'(w_prod);
        end
        if (r_state == eps_pkg::ST_MUL_POS) begin
            r_acc <= r_acc + eps_pkg::ACC_W'(w_prod)
                     + eps_pkg::ACC_W'(1 << (eps_pkg::FILT_SHIFT - 1));
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_word.position_count  <= 32'(r_count);
            r_out_word.position_scaled <= eps_pkg::POS_W'(w_prod);
            r_out_word.speed_raw       <= r_raw;
            r_out_word.speed_filtered  <= w_filt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == eps_pkg::ST_DIV))
        else $error("divider finished outside the divide phase");

    a_tick_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick_acc |=> (r_state == eps_pkg::ST_DIV))
        else $error("tick word did not start the divide");

    a_edge_keeps_filter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_edge_acc |=> $stable(r_speed_state))
        else $error("edge word changed the filter state");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == eps_pkg::ST_OUT))
        else $error("result appeared outside the output phase");

    a_zero_gap_zero_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == eps_pkg::ST_MUL_OLD) && (w_gap == '0)) |-> (r_raw == '0))
        else $error("zero edge gap gave a nonzero raw speed");

endmodule

`default_nettype wire
